[rtl/core/i2a_pkg.sv]
// Shared types, codes and helpers for the integer-to-ASCII formatter.
package i2a_pkg;

  localparam logic [2:0] OP_SDEC  = 3'd0;
  localparam logic [2:0] OP_UDEC  = 3'd1;
  localparam logic [2:0] OP_HEXL  = 3'd2;
  localparam logic [2:0] OP_HEXU  = 3'd3;
  localparam logic [2:0] OP_HEX64 = 3'd4;

  localparam int unsigned BIN_W    = 32;
  localparam int unsigned BCD_DIGS = 10;
  localparam int unsigned BCD_W    = 4 * BCD_DIGS;

  localparam logic [7:0]  CH_MINUS  = 8'h2D;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic       push;
    logic [7:0] ch;
    logic       last;
  } i2a_char_t;

  function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib, input logic upper);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else if (upper) begin
      r = 8'h41 + {4'd0, nib} - 8'd10;
    end else begin
      r = 8'h61 + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

[rtl/core/integer_to_ascii_formatter.sv]
// Integer to ASCII formatter top level: mode decode, digit shifter, sequencer.
// A hex item goes straight to the digit shifter; a decimal item first passes through the
// BCD converter, and a negative one emits a minus sign. Leading zero digits are skipped
// one per cycle. One item at a time: the next is accepted only after the last character
// of the previous one has entered the result register, which the result side can stall.
// Reset (synchronous, active low) clears the sequencer, output valid and count.
module integer_to_ascii_formatter
  import i2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_ch,
  output logic        out_last,
  output logic [31:0] out_chars_total
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] dig_r, dig_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        started_r, started_nxt;
  logic        upper_r, upper_nxt;
  logic        neg_r, neg_nxt;

  logic             in_fire;
  logic [31:0]      x;
  logic             bcd_start;
  logic [BIN_W-1:0] bcd_bin;
  logic             bcd_done;
  logic [BCD_W-1:0] bcd_val;
  i2a_char_t        chr;
  logic             out_free;
  logic [3:0]       nib;
  logic             last_dig;
  logic             show;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign x        = in_value[31:0];
  assign nib      = dig_r[63:60];
  assign last_dig = (cnt_r == 5'd1);
  assign show     = (nib != 4'd0) || started_r || last_dig;

  always_comb begin
    state_nxt   = state_r;
    dig_nxt     = dig_r;
    cnt_nxt     = cnt_r;
    started_nxt = started_r;
    upper_nxt   = upper_r;
    neg_nxt     = neg_r;
    bcd_start   = 1'b0;
    bcd_bin     = x;
    chr         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          started_nxt = 1'b0;
          upper_nxt   = (in_op == OP_HEXU);
          neg_nxt     = 1'b0;
          case (in_op)
            OP_SDEC: begin
              neg_nxt   = x[31];
              bcd_bin   = x[31] ? (32'd0 - x) : x;
              bcd_start = 1'b1;
              state_nxt = ST_CONV;
            end
            OP_UDEC: begin
              bcd_start = 1'b1;
              state_nxt = ST_CONV;
            end
            OP_HEXL, OP_HEXU: begin
              dig_nxt   = {x, 32'd0};
              cnt_nxt   = 5'd8;
              state_nxt = ST_EMIT;
            end
            OP_HEX64: begin
              dig_nxt   = in_value;
              cnt_nxt   = 5'd16;
              state_nxt = ST_EMIT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          dig_nxt   = {bcd_val, 24'd0};
          cnt_nxt   = 5'(BCD_DIGS);
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        chr.push = 1'b1;
        chr.ch   = CH_MINUS;
        chr.last = 1'b0;
        if (out_free) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (show) begin
          chr.push = 1'b1;
          chr.ch   = nib_to_ascii(nib, upper_r);
          chr.last = last_dig;
          if (out_free) begin
            dig_nxt     = {dig_r[59:0], 4'd0};
            cnt_nxt     = cnt_r - 5'd1;
            started_nxt = 1'b1;
            if (last_dig) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          dig_nxt = {dig_r[59:0], 4'd0};
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    dig_r     <= dig_nxt;
    cnt_r     <= cnt_nxt;
    started_r <= started_nxt;
    upper_r   <= upper_nxt;
    neg_r     <= neg_nxt;
  end

  i2a_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bcd_start),
    .bin   (bcd_bin),
    .done  (bcd_done),
    .bcd   (bcd_val)
  );

  i2a_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .chr             (chr),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ch          (out_ch),
    .out_last        (out_last),
    .out_chars_total (out_chars_total)
  );

  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> cnt_r != 5'd0)
    else $error("emit with no digits left");

  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_done |-> state_r == ST_CONV)
    else $error("bcd result outside conversion");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (chr.push && out_free && chr.last) |=> state_r == ST_IDLE)
    else $error("last character did not end the item");

endmodule

[rtl/core/i2a_bcd.sv]
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module i2a_bcd
  import i2a_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [BIN_W-1:0] bin,
  output logic             done,
  output logic [BCD_W-1:0] bcd
);

  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] bcd_adj;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    for (int i = 0; i < BCD_DIGS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt = bin;
      bcd_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[BIN_W-1]};
      bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(BIN_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> cnt_r < 6'(BIN_W))
    else $error("bcd bit counter out of range");

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r)
    else $error("bcd done while still running");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("bcd done held more than one cycle");

endmodule

[rtl/core/i2a_out.sv]
// Result register with skid-free handoff and saturating character counter.
module i2a_out
  import i2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  i2a_char_t   chr,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_ch,
  output logic        out_last,
  output logic [31:0] out_chars_total
);

  logic        valid_r, valid_nxt;
  logic [7:0]  ch_r;
  logic        last_r;
  logic [31:0] total_r;
  logic [31:0] count_r, count_nxt;
  logic        fire;

  assign free = !valid_r || out_ready;
  assign fire = chr.push && free;

  always_comb begin
    count_nxt = count_r;
    if (fire && count_r != COUNT_MAX) begin
      count_nxt = count_r + 32'd1;
    end
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
    if (fire) begin
      ch_r    <= chr.ch;
      last_r  <= chr.last;
      total_r <= count_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_ch          = ch_r;
  assign out_last        = last_r;
  assign out_chars_total = total_r;

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && count_r != COUNT_MAX) |=> count_r == $past(count_r) + 32'd1)
    else $error("character count did not advance");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == COUNT_MAX) |=> count_r == COUNT_MAX)
    else $error("character count left saturation");

  a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> total_r == count_r)
    else $error("reported total differs from counter");

endmodule

[sim/testbench.sv]
// Testbench for integer_to_ascii_formatter: directed table, random items, per-character checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import i2a_pkg::*;

  localparam logic [2:0] OP_RSVD_LO  = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_HI  = 3'd7;
  localparam logic [2:0] FORMAT_OPS [5] = '{OP_SDEC, OP_UDEC, OP_HEXL, OP_HEXU, OP_HEX64};
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [2:0]   op;
    logic [63:0]  value;
    logic         typed;
    logic [127:0] text;
  } row_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic [31:0] total;
  } printed_char_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [63:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_ch;
  logic        out_last;
  logic [31:0] out_chars_total;

  printed_char_t expected_chars[$];
  logic [7:0]    number_text[$];
  row_t          directed[$];
  logic [31:0]   chars_emitted;
  int            mismatches;
  logic          long_hold;

  integer_to_ascii_formatter i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ch          (out_ch),
    .out_last        (out_last),
    .out_chars_total (out_chars_total)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic row_t stim_row(input logic [2:0] op, input logic [63:0] value,
                                    input logic typed, input logic [127:0] text);
    row_t r;
    r.op    = op;
    r.value = value;
    r.typed = typed;
    r.text  = text;
    return r;
  endfunction

  // typed rows carry their text right-aligned; otherwise the digits are worked out here
  task automatic predict_item(input row_t r);
    logic [63:0] mag;
    logic [31:0] mag32;
    logic [63:0] base;
    logic [63:0] d;
    logic        neg;
    logic        upper;
    logic        known;
    number_text.delete();
    neg   = 1'b0;
    upper = 1'b0;
    known = 1'b1;
    base  = 64'd16;
    mag   = {32'd0, r.value[31:0]};
    if (r.typed) begin
      for (int i = 15; i >= 0; i--)
        if (r.text[i*8 +: 8] != 8'd0) number_text.push_back(r.text[i*8 +: 8]);
    end else begin
      case (r.op)
        OP_SDEC: begin
          base = 64'd10;
          neg = r.value[31];
          mag32 = neg ? 32'd0 - r.value[31:0] : r.value[31:0];
          mag = {32'd0, mag32};
        end
        OP_UDEC: base = 64'd10;
        OP_HEXL: ;
        OP_HEXU: upper = 1'b1;
        OP_HEX64: mag = r.value;
        default: known = 1'b0;
      endcase
      if (known) begin
        do begin
          d = mag % base;
          if (d < 10) number_text.push_front(8'h30 + d[7:0]);
          else if (upper) number_text.push_front(8'h41 + d[7:0] - 8'd10);
          else number_text.push_front(8'h61 + d[7:0] - 8'd10);
          mag = mag / base;
        end while (mag != 64'd0);
        if (neg) number_text.push_front(CH_MINUS);
      end
    end
    foreach (number_text[i]) begin
      if (chars_emitted != COUNT_MAX) chars_emitted = chars_emitted + 32'd1;
      expected_chars.push_back({number_text[i], i == number_text.size() - 1, chars_emitted});
    end
  endtask

  task automatic send_item(input row_t r);
    in_valid <= 1'b1;
    in_op    <= r.op;
    in_value <= r.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 100)
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    printed_char_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character", {24'd0, out_ch}, 32'd0);
      end else begin
        e = expected_chars.pop_front();
        if (out_ch !== e.ch) report_mismatch("ch", {24'd0, out_ch}, {24'd0, e.ch});
        if (out_last !== e.last) report_mismatch("last", {31'd0, out_last}, {31'd0, e.last});
        if (out_chars_total !== e.total) report_mismatch("chars_total", out_chars_total, e.total);
      end
    end
  end

  // receiver: ready patterns in stretches, plus one long hold-off on request
  initial begin
    int  mode;
    int  span;
    int  phase;
    bit  held;
    held  = 1'b0;
    phase = 0;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 64);
      repeat (span) begin
        @(posedge clk);
        phase++;
        if (long_hold && !held) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (phase % 4 == 0);
            default: out_ready <= (phase % 4 != 0);
          endcase
        end
      end
    end
  end

  initial begin
    row_t        r;
    int          sent;
    int          burst_left;
    logic [63:0] p;
    chars_emitted = 32'd0;
    mismatches    = 0;
    long_hold    <= 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_op        <= OP_SDEC;
    in_value     <= 64'd0;

    directed.push_back(stim_row(OP_SDEC, 64'd0, 1'b1, "0"));
    directed.push_back(stim_row(OP_SDEC, 64'h0000_0000_8000_0000, 1'b1, "-2147483648"));
    directed.push_back(stim_row(OP_SDEC, 64'h0000_0000_7FFF_FFFF, 1'b1, "2147483647"));
    directed.push_back(stim_row(OP_SDEC, 64'h0000_0000_FFFF_FFFF, 1'b1, "-1"));
    directed.push_back(stim_row(OP_SDEC, 64'hDEAD_BEEF_0000_0005, 1'b1, "5"));
    directed.push_back(stim_row(OP_SDEC, 64'd10, 1'b1, "10"));
    directed.push_back(stim_row(OP_SDEC, 64'hFFFF_FFFF_FFFF_FFF6, 1'b0, 128'd0));
    directed.push_back(stim_row(OP_UDEC, 64'd0, 1'b1, "0"));
    directed.push_back(stim_row(OP_UDEC, 64'h0000_0000_FFFF_FFFF, 1'b1, "4294967295"));
    directed.push_back(stim_row(OP_UDEC, 64'hFFFF_FFFF_0000_0000, 1'b1, "0"));
    directed.push_back(stim_row(OP_UDEC, 64'd1_000_000_000, 1'b0, 128'd0));
    directed.push_back(stim_row(OP_HEXL, 64'd0, 1'b1, "0"));
    directed.push_back(stim_row(OP_HEXL, 64'h0000_0000_FFFF_FFFF, 1'b1, "ffffffff"));
    directed.push_back(stim_row(OP_HEXL, 64'h1234_5678_ABCD_EF12, 1'b0, 128'd0));
    directed.push_back(stim_row(OP_HEXU, 64'h0000_0000_FFFF_FFFF, 1'b1, "FFFFFFFF"));
    directed.push_back(stim_row(OP_HEXU, 64'h0000_0000_0000_ABCD, 1'b1, "ABCD"));
    directed.push_back(stim_row(OP_HEX64, 64'd0, 1'b1, "0"));
    directed.push_back(stim_row(OP_HEX64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "ffffffffffffffff"));
    directed.push_back(stim_row(OP_HEX64, 64'h8000_0000_0000_0000, 1'b1, "8000000000000000"));
    directed.push_back(stim_row(OP_HEX64, 64'h0123_4567_89AB_CDEF, 1'b0, 128'd0));
    directed.push_back(stim_row(OP_RSVD_LO, 64'd123, 1'b1, ""));
    directed.push_back(stim_row(OP_RSVD_MID, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ""));
    directed.push_back(stim_row(OP_RSVD_HI, 64'd0, 1'b1, ""));
    directed.push_back(stim_row(OP_HEXL, 64'd7, 1'b1, "7"));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i]);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    @(posedge clk);

    sent = 0;
    burst_left = $urandom_range(1, 12);
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) r.op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      else r.op = FORMAT_OPS[$urandom_range(0, 4)];
      case ($urandom_range(0, 3))
        0: r.value = {$urandom, $urandom};
        1: r.value = {$urandom, $urandom} >> (64 - $urandom_range(1, 64));
        2: begin
          p = 64'd1;
          if ($urandom_range(0, 1) == 0) repeat ($urandom_range(0, 19)) p = p * 64'd10;
          else repeat ($urandom_range(0, 15)) p = p * 64'd16;
          r.value = p - 64'd1 + 64'($urandom_range(0, 2));
        end
        default: r.value = 64'd0 - 64'($urandom_range(1, 100000));
      endcase
      r.typed = 1'b0;
      r.text  = 128'd0;
      send_item(r);
      if (r.op <= OP_HEX64) sent++;
      if (sent == 20) long_hold <= 1'b1;
      burst_left--;
      if (sent == 250 && r.op <= OP_HEX64) begin
        in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
        @(posedge clk);
      end else if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      end
    end

    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
